// File: hdl/srb_pkg.sv
// Shared widths, codes and defaults for the sequence reorder buffer.
package srb_pkg;

   localparam int SEQ_W            = 32;
   localparam int HANDLE_W         = 32;
   localparam int WINDOW_DEF       = 16;
   localparam int PAYLOAD_BITS_DEF = 32;

   // action codes
   localparam logic ACT_MESSAGE = 1'b0;
   localparam logic ACT_RESET   = 1'b1;

   // result status codes
   localparam logic STATUS_DELIVERED = 1'b0;
   localparam logic STATUS_DROPPED   = 1'b1;

endpackage

// File: hdl/srb_req_if.sv
// Request channel: one incoming message or session reset per word.
interface srb_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [srb_pkg::SEQ_W-1:0]     seq_id;
   logic                          sender;
   logic [srb_pkg::HANDLE_W-1:0]  payload_handle;

   modport source (output valid, action, seq_id, sender, payload_handle, input ready);
   modport sink   (input valid, action, seq_id, sender, payload_handle, output ready);
endinterface

// File: hdl/srb_rsp_if.sv
// Response channel: one delivered or dropped message per word.
interface srb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [srb_pkg::SEQ_W-1:0]     out_seq_id;
   logic                          out_sender;
   logic [srb_pkg::HANDLE_W-1:0]  out_payload;
   logic                          last;

   modport source (output valid, status, out_seq_id, out_sender, out_payload, last,
                   input ready);
   modport sink   (input valid, status, out_seq_id, out_sender, out_payload, last,
                   output ready);
endinterface

// File: hdl/sequence_reorder_buffer_unit.sv
// Sequence reorder buffer: parks out-of-order messages and releases them in order.
//
// Usage: messages enter on req_bus (valid/ready), results leave on rsp_bus.
// A word is taken on a clock edge with valid and ready both high.
// A message equal to the expected number is delivered at once; parked
// messages that become due then follow, one word per cycle while not stalled,
// the final word of the run flagged with last. Messages below the expected
// number are ignored; those ahead within WINDOW are parked (first copy wins)
// and give no word; those further ahead give one word with status dropped.
// The first result word is registered and valid the cycle after the request
// is taken. While a run drains, one parked entry is read per cycle from the
// slot memory, and the next read waits while a result word is stalled.
// req_bus.ready is low while a run drains or while a result word waits and
// rsp_bus.ready is low; a stalled result word holds its value.
// Reset (synchronous) and a session reset request both set the expected
// number to 1 and empty every slot at once; neither gives a result word.
module sequence_reorder_buffer_unit #(
   parameter int WINDOW       = srb_pkg::WINDOW_DEF,
   parameter int PAYLOAD_BITS = srb_pkg::PAYLOAD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   srb_req_if.sink   req_bus,
   srb_rsp_if.source rsp_bus
);

   localparam int SW      = srb_pkg::SEQ_W;
   localparam int HW      = srb_pkg::HANDLE_W;
   localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int ENTRY_W = PAYLOAD_BITS + 1;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                state_ff, state_in;
   logic [SW-1:0]       exp_ff, exp_in;
   logic [IDX_W-1:0]    exp_idx_ff, exp_idx_in;
   logic [WINDOW-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                status_ff, status_in;
   logic [SW-1:0]       seq_out_ff, seq_out_in;
   logic                sender_ff, sender_in;
   logic [HW-1:0]       payload_ff, payload_in;
   logic                last_ff, last_in;

   // slot memory: {sender, payload}
   logic [ENTRY_W-1:0]  slot_mem [WINDOW];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                mem_we, mem_re;
   logic [IDX_W-1:0]    mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0]  mem_wdata;

   logic                out_free, accept;
   logic [SW-1:0]       ahead;
   logic                is_dup, is_now, beyond;
   logic [IDX_W:0]      park_sum;
   logic [IDX_W-1:0]    park_idx;
   logic [IDX_W-1:0]    nxt_idx;
   logic                nxt_valid;
   logic [PAYLOAD_BITS-1:0] pay_keep;
   logic [CNT_W-1:0]    cnt_next;
   logic                drain_last;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign ahead    = req_bus.seq_id - exp_ff;
   assign is_dup   = req_bus.seq_id < exp_ff;
   assign is_now   = req_bus.seq_id == exp_ff;
   assign beyond   = ahead >= SW'(WINDOW);
   // seq mod WINDOW from the tracked residue of the expected number
   assign park_sum = (IDX_W+1)'(exp_idx_ff) + (IDX_W+1)'(ahead[IDX_W-1:0]);
   assign park_idx = (park_sum >= (IDX_W+1)'(WINDOW)) ?
                     IDX_W'(park_sum - (IDX_W+1)'(WINDOW)) : IDX_W'(park_sum);
   assign pay_keep = PAYLOAD_BITS'(req_bus.payload_handle);

   // residue of expected+1; at the 2^32 wrap the number restarts at 0
   always_comb begin
      if (exp_ff == {SW{1'b1}}) begin
         nxt_idx = '0;
      end else if (exp_idx_ff == IDX_W'(WINDOW - 1)) begin
         nxt_idx = '0;
      end else begin
         nxt_idx = exp_idx_ff + IDX_W'(1);
      end
   end

   // the current slot is emptied as it leaves, so a same-index hit is not valid
   assign nxt_valid  = valid_ff[nxt_idx] && (nxt_idx != exp_idx_ff);
   assign cnt_next   = cnt_ff + CNT_W'(1);
   assign drain_last = (cnt_next == CNT_W'(WINDOW)) || !nxt_valid;

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      exp_idx_in   = exp_idx_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      seq_out_in   = seq_out_ff;
      sender_in    = sender_ff;
      payload_in   = payload_ff;
      last_in      = last_ff;
      mem_we       = 1'b0;
      mem_waddr    = park_idx;
      mem_wdata    = {req_bus.sender, pay_keep};
      mem_re       = 1'b0;
      mem_raddr    = nxt_idx;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.action == srb_pkg::ACT_RESET) begin
                  exp_in     = SW'(1);
                  exp_idx_in = IDX_W'(1);
                  valid_in   = '0;
               end else if (is_dup) begin
                  // duplicate, nothing to do
               end else if (is_now) begin
                  rsp_valid_in = 1'b1;
                  status_in    = srb_pkg::STATUS_DELIVERED;
                  seq_out_in   = req_bus.seq_id;
                  sender_in    = req_bus.sender;
                  payload_in   = HW'(pay_keep);
                  last_in      = !nxt_valid;
                  exp_in       = exp_ff + SW'(1);
                  exp_idx_in   = nxt_idx;
                  if (nxt_valid) begin
                     mem_re   = 1'b1;
                     cnt_in   = CNT_W'(1);
                     state_in = ST_DRAIN;
                  end
               end else if (beyond) begin
                  rsp_valid_in = 1'b1;
                  status_in    = srb_pkg::STATUS_DROPPED;
                  seq_out_in   = req_bus.seq_id;
                  sender_in    = 1'b0;
                  payload_in   = '0;
                  last_in      = 1'b1;
               end else if (!valid_ff[park_idx]) begin
                  mem_we             = 1'b1;
                  valid_in[park_idx] = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               status_in            = srb_pkg::STATUS_DELIVERED;
               seq_out_in           = exp_ff;
               sender_in            = rd_data_ff[PAYLOAD_BITS];
               payload_in           = HW'(rd_data_ff[PAYLOAD_BITS-1:0]);
               last_in              = drain_last;
               valid_in[exp_idx_ff] = 1'b0;
               exp_in               = exp_ff + SW'(1);
               exp_idx_in           = nxt_idx;
               cnt_in               = cnt_next;
               if (drain_last) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_re = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exp_ff       <= SW'(1);
         exp_idx_ff   <= IDX_W'(1);
         valid_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         exp_idx_ff   <= exp_idx_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      seq_out_ff <= seq_out_in;
      sender_ff  <= sender_in;
      payload_ff <= payload_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem[mem_raddr];
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.out_seq_id  = seq_out_ff;
   assign rsp_bus.out_sender  = sender_ff;
   assign rsp_bus.out_payload = payload_ff;
   assign rsp_bus.last        = last_ff;

endmodule
